// ===== sv/positional_list_engine_assert.svh =====
// Assertion macros used by the checker of the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list engine: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list engine: next-cycle check failed");

`endif

// ===== sv/ple_pkg.sv =====
// Types, widths and codes shared by the positional list engine.
package ple_pkg;

  localparam int CAPACITY    = 64;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int OP_W        = 2;
  localparam int POS_W       = 7;
  localparam int DATA_W      = 32;
  localparam int ST_W        = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_SHIFT,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX1,
    RD_IDX2
  } rd_ofs_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_ofs_t rd_ofs;
    logic    wr_en;
    logic    wr_tail;
    logic    wr_shift;
    logic    idx_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    st_load;
    status_t st_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic range_bad;
    logic more_after_pos;
    logic more_shift;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/ple_if.sv =====
// Request and response channel interfaces of the positional list engine.
interface ple_req_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic [6:0]              position;
  logic signed [31:0]      value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ple_rsp_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      read_value;
  logic [1:0]              status;
  logic [6:0]              count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

// ===== sv/ple_ctrl.sv =====
// Controller state machine of the positional list engine.
module ple_ctrl import ple_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  stat_t  stat,
  output cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.st_load = 1'b1;
        state_next  = S_FINISH;
        if (stat.op == OP_APPEND) begin
          if (stat.full) begin
            cmd.st_code = ST_FULL;
          end else begin
            cmd.st_code = ST_OK;
            cmd.wr_en   = 1'b1;
            cmd.wr_tail = 1'b1;
            cmd.cnt_inc = 1'b1;
          end
        end else if (stat.empty) begin
          cmd.st_code = ST_EMPTY;
        end else if (stat.range_bad) begin
          cmd.st_code = ST_RANGE;
        end else begin
          cmd.st_code = ST_OK;
          case (stat.op)
            OP_DELETE: begin
              // Prefetch the entry after the hole; the last entry needs no shift.
              if (stat.more_after_pos) begin
                cmd.rd_en  = 1'b1;
                cmd.rd_ofs = RD_IDX1;
                state_next = S_SHIFT;
              end else begin
                cmd.cnt_dec = 1'b1;
              end
            end
            OP_READ: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_ofs = RD_IDX;
              state_next = S_READ;
            end
            OP_WRITE: begin
              cmd.wr_en = 1'b1;
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_FINISH;
      end
      S_SHIFT: begin
        // One entry moves down per cycle while the next one is fetched.
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (stat.more_shift) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_ofs = RD_IDX2;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ple_datapath.sv =====
// Datapath of the positional list engine: entry memory, count, pointers and result register.
module ple_datapath import ple_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output stat_t                      stat,
  input  logic [OP_W-1:0]            in_op,
  input  logic [POS_W-1:0]           in_position,
  input  logic signed [DATA_W-1:0]   in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   out_read_value,
  output logic [ST_W-1:0]            out_status,
  output logic [COUNT_OUT_W-1:0]     out_count
);

  logic [DATA_W-1:0] mem [CAPACITY];

  op_t                 op_r;
  logic [POS_W-1:0]    pos_r;
  logic [DATA_W-1:0]   val_r;
  logic [IDX_W-1:0]    idx;
  logic [CNT_W-1:0]    count;
  status_t             st_r;
  logic [DATA_W-1:0]   rdata;

  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic [CMP_W-1:0]    pos_c;
  logic [CMP_W-1:0]    cnt_c;
  logic [CMP_W-1:0]    in_pos_c;

  assign pos_c    = CMP_W'(pos_r);
  assign cnt_c    = CMP_W'(count);
  assign in_pos_c = CMP_W'(in_position);

  always_comb begin
    case (cmd.rd_ofs)
      RD_IDX:  rd_addr = idx;
      RD_IDX1: rd_addr = idx + IDX_W'(1);
      RD_IDX2: rd_addr = idx + IDX_W'(2);
      default: rd_addr = idx;
    endcase
  end

  assign wr_addr = cmd.wr_tail ? IDX_W'(count) : idx;
  assign wr_data = cmd.wr_shift ? rdata : val_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Request fields and working pointer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_op);
      pos_r <= in_position;
      val_r <= in_value;
      idx   <= IDX_W'(in_pos_c - CMP_W'(1));
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.st_load) begin
      st_r <= cmd.st_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CNT_W'(1);
    end
  end

  // Result register frees the controller while a beat waits downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_value <= (op_r == OP_READ && st_r == ST_OK) ? rdata : '0;
      out_status     <= st_r;
      out_count      <= COUNT_OUT_W'(cnt_c);
    end
  end

  always_comb begin
    stat.op             = op_r;
    stat.full           = (count == CNT_W'(CAPACITY));
    stat.empty          = (count == '0);
    stat.range_bad      = (pos_c == '0) || (pos_c > cnt_c);
    stat.more_after_pos = (pos_c < cnt_c);
    stat.more_shift     = ((CMP_W'(idx) + CMP_W'(2)) < cnt_c);
    stat.out_free       = !out_valid || out_ready;
  end

endmodule

// ===== sv/positional_list_engine.sv =====
// A request beat is accepted in S_IDLE and decided in S_DECIDE; a read then passes through S_READ,
// and a delete at position p shifts the count - p entries after it (count before the delete) in S_SHIFT.
// S_FINISH loads the result beat once the output register is free. One request is in work at a time.
// The next request is taken while the previous result beat still waits in the output register.
// Reset (rst, synchronous, active high) empties the list; entry memory is not cleared.
module positional_list_engine import ple_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ple_req_if.sink       req,
  ple_rsp_if.source     rsp
);

  cmd_t  cmd;
  stat_t stat;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ple_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_op          (req.op),
    .in_position    (req.position),
    .in_value       (req.value),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_read_value (rsp.read_value),
    .out_status     (rsp.status),
    .out_count      (rsp.count)
  );

endmodule

// ===== sv/ple_checker.sv =====
// Port-level checker for the positional list engine and its bind.
`include "positional_list_engine_assert.svh"

module ple_checker import ple_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic signed [DATA_W-1:0] rsp_read_value,
  input logic [ST_W-1:0]          rsp_status,
  input logic [COUNT_OUT_W-1:0]   rsp_count
);

  // A stalled result beat keeps its contents.
  `PLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_read_value))

  // Only one request is in work at a time.
  `PLE_ASSERT_NEXT(a_one_in_work, req_valid && req_ready, !req_ready)

  // A failed request never returns data.
  `PLE_ASSERT_NOW(a_no_data_on_error, rsp_valid && (rsp_status != ST_OK), rsp_read_value == '0)

  // A full report always comes with the list at capacity.
  `PLE_ASSERT_NOW(a_full_count, rsp_valid && (rsp_status == ST_FULL), rsp_count == COUNT_OUT_W'(CAPACITY))

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_value (rsp.read_value),
  .rsp_status     (rsp.status),
  .rsp_count      (rsp.count)
);
